// File: rtl/fsfl_pkg.sv
package fsfl_pkg;

    localparam int BLOCK_SIZE  = 16;
    localparam int MAX_BLOCKS  = 16;
    localparam int SLOT_SPACE  = 256;
    localparam int SLOT_W      = $clog2(SLOT_SPACE);
    localparam int LINK_W      = SLOT_W + 1;
    localparam int BLK_W       = $clog2(MAX_BLOCKS + 1);
    localparam int ALLOWED_W   = 5;
    localparam int FILL_CNT_W  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int GROW_LIMIT  = (MAX_BLOCKS < SLOT_SPACE / BLOCK_SIZE) ?
                                 MAX_BLOCKS : SLOT_SPACE / BLOCK_SIZE;

    localparam logic [LINK_W-1:0]    NULL_LINK       = LINK_W'(SLOT_SPACE);
    localparam logic [ALLOWED_W-1:0] ALLOWED_RESET   = ALLOWED_W'(16);
    localparam logic [FILL_CNT_W-1:0] FILL_CNT_START = FILL_CNT_W'(BLOCK_SIZE - 1);

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_IDLE  = 4'd0;
    localparam step_t ST_ACHK  = 4'd1;
    localparam step_t ST_GCHK  = 4'd2;
    localparam step_t ST_GSET  = 4'd3;
    localparam step_t ST_GFILL = 4'd4;
    localparam step_t ST_GDONE = 4'd5;
    localparam step_t ST_PRD   = 4'd6;
    localparam step_t ST_POP   = 4'd7;
    localparam step_t ST_FREE  = 4'd8;
    localparam step_t ST_FAIL  = 4'd9;

    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_OP_FREE   = 3'd2,
        C_HEAD_OK   = 3'd3,
        C_NO_GROW   = 3'd4,
        C_FILL_MORE = 3'd5,
        C_NO_ITEM   = 3'd6
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  need_out;
        logic  link_rd;
        logic  grow_set;
        logic  fill;
        logic  do_pop;
        logic  do_free;
        logic  do_fail;
        cond_t cond;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t u;
        u = '{take_in: 1'b0, need_out: 1'b0, link_rd: 1'b0, grow_set: 1'b0,
              fill: 1'b0, do_pop: 1'b0, do_free: 1'b0, do_fail: 1'b0,
              cond: C_ALWAYS, target: ST_IDLE};
        unique case (s)
            ST_IDLE:
            begin
                u.take_in = 1'b1;
                u.cond    = C_OP_FREE;
                u.target  = ST_FREE;
            end
            ST_ACHK:
            begin
                u.link_rd = 1'b1;
                u.cond    = C_HEAD_OK;
                u.target  = ST_POP;
            end
            ST_GCHK:
            begin
                u.cond   = C_NO_GROW;
                u.target = ST_FAIL;
            end
            ST_GSET:
            begin
                u.grow_set = 1'b1;
                u.cond     = C_NEXT;
            end
            ST_GFILL:
            begin
                u.fill   = 1'b1;
                u.cond   = C_FILL_MORE;
                u.target = ST_GFILL;
            end
            ST_GDONE:
            begin
                u.cond   = C_NO_ITEM;
                u.target = ST_IDLE;
            end
            ST_PRD:
            begin
                u.link_rd = 1'b1;
                u.cond    = C_NEXT;
            end
            ST_POP:
            begin
                u.need_out = 1'b1;
                u.do_pop   = 1'b1;
            end
            ST_FREE:
            begin
                u.need_out = 1'b1;
                u.do_free  = 1'b1;
            end
            ST_FAIL:
            begin
                u.need_out = 1'b1;
                u.do_fail  = 1'b1;
            end
            default:
            begin
                u.cond   = C_ALWAYS;
                u.target = ST_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// File: rtl/fsfl_if.sv
interface fsfl_req_if;
    import fsfl_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic              slot_given;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output opcode, output slot_given, output slot_index,
                    input ready);
    modport sink   (input valid, input opcode, input slot_given, input slot_index,
                    output ready);
endinterface

interface fsfl_rsp_if;
    import fsfl_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_index_out;
    logic              alloc_failed;

    modport source (output valid, output slot_index_out, output alloc_failed,
                    input ready);
    modport sink   (input valid, input slot_index_out, input alloc_failed,
                    output ready);
endinterface

// File: rtl/fixed_slot_free_list_allocator.sv
// channel    dir   fields                                  transfer when
// req        in    opcode, slot_given, slot_index          valid && ready
// rsp        out   slot_index_out, alloc_failed            valid && ready
// cfg        in    cfg_wdata (blocks_allowed)              cfg_we
//
// free and allocate from a non-empty list are sequenced by the microcode
// steps around the single-port link memory read and write.
// allocate with growth adds the grow steps, one link write per slot.
// after reset block 0 is linked by the same fill routine, while req.ready
// stays low. a held result stalls the final step only; the
// result register lets the next request be taken while rsp waits.
module fixed_slot_free_list_allocator
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fsfl_pkg::ALLOWED_W-1:0]     cfg_wdata,
    fsfl_req_if.sink                           req,
    fsfl_rsp_if.source                         rsp
);
    import fsfl_pkg::*;

    step_t                   step_reg, step_next;
    ucode_t                  uc;
    logic                    stall;
    logic                    cond_true;

    logic [ALLOWED_W-1:0]    allowed_reg;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [BLK_W-1:0]        blocks_reg, blocks_next;
    logic                    pend_reg, pend_next;
    logic                    op_reg;
    logic                    given_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [SLOT_W-1:0]       base_reg;
    logic [SLOT_W-1:0]       fill_addr_reg;
    logic [FILL_CNT_W-1:0]   fill_cnt_reg;

    logic [LINK_W-1:0]       link_mem [SLOT_SPACE];
    logic [LINK_W-1:0]       rd_data_reg;
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_waddr;
    logic [LINK_W-1:0]       mem_wdata;

    logic                    rsp_valid_reg;
    logic [SLOT_W-1:0]       rsp_slot_reg;
    logic                    rsp_fail_reg;
    logic                    rsp_load;
    logic                    can_grow;
    logic                    req_xfer;

    assign uc        = ucode_rom(step_reg);
    assign stall     = (uc.take_in && !req.valid) ||
                       (uc.need_out && rsp_valid_reg && !rsp.ready);
    assign req.ready = uc.take_in;
    assign req_xfer  = req.valid && uc.take_in;
    assign can_grow  = (ALLOWED_W'(blocks_reg) < allowed_reg) &&
                       (32'(blocks_reg) < GROW_LIMIT);
    assign rsp_load  = uc.need_out && !stall;

    always_comb
    begin
        unique case (uc.cond)
            C_NEXT:      cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_OP_FREE:   cond_true = (req.opcode == OP_FREE);
            C_HEAD_OK:   cond_true = (head_reg != NULL_LINK);
            C_NO_GROW:   cond_true = !can_grow;
            C_FILL_MORE: cond_true = (fill_cnt_reg != '0);
            C_NO_ITEM:   cond_true = !pend_reg;
            default:     cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (cond_true)
        begin
            step_next = uc.target;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    // link memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = fill_addr_reg;
        mem_wdata = head_reg;
        if (uc.fill)
        begin
            mem_we    = 1'b1;
            mem_waddr = fill_addr_reg;
            mem_wdata = (fill_cnt_reg == '0) ? head_reg :
                        LINK_W'(fill_addr_reg) + LINK_W'(1);
        end
        else if (uc.do_free && given_reg && !stall)
        begin
            mem_we    = 1'b1;
            mem_waddr = slot_reg;
            mem_wdata = head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (uc.link_rd)
        begin
            rd_data_reg <= link_mem[head_reg[SLOT_W-1:0]];
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        blocks_next = blocks_reg;
        pend_next   = pend_reg;
        if (req_xfer)
        begin
            pend_next = 1'b1;
        end
        if (uc.fill && fill_cnt_reg == '0)
        begin
            head_next   = LINK_W'(base_reg);
            blocks_next = blocks_reg + BLK_W'(1);
        end
        if (rsp_load)
        begin
            pend_next = 1'b0;
            if (uc.do_pop)
            begin
                head_next = rd_data_reg;
            end
            if (uc.do_free && given_reg)
            begin
                head_next = LINK_W'(slot_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_GSET;
            allowed_reg   <= ALLOWED_RESET;
            head_reg      <= NULL_LINK;
            blocks_reg    <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            head_reg   <= head_next;
            blocks_reg <= blocks_next;
            pend_reg   <= pend_next;
            if (cfg_we)
            begin
                allowed_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg    <= req.opcode;
            given_reg <= req.slot_given;
            slot_reg  <= req.slot_index;
        end
        if (uc.grow_set)
        begin
            base_reg      <= SLOT_W'(32'(blocks_reg) * BLOCK_SIZE);
            fill_addr_reg <= SLOT_W'(32'(blocks_reg) * BLOCK_SIZE);
            fill_cnt_reg  <= FILL_CNT_START;
        end
        else if (uc.fill)
        begin
            fill_addr_reg <= fill_addr_reg + SLOT_W'(1);
            fill_cnt_reg  <= fill_cnt_reg - FILL_CNT_W'(1);
        end
        if (rsp_load)
        begin
            priority if (uc.do_pop && op_reg == OP_ALLOC)
            begin
                rsp_slot_reg <= head_reg[SLOT_W-1:0];
                rsp_fail_reg <= 1'b0;
            end
            else if (uc.do_free && given_reg)
            begin
                rsp_slot_reg <= slot_reg;
                rsp_fail_reg <= 1'b0;
            end
            else
            begin
                rsp_slot_reg <= '0;
                rsp_fail_reg <= uc.do_fail;
            end
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.slot_index_out = rsp_slot_reg;
    assign rsp.alloc_failed   = rsp_fail_reg;

endmodule

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsfl_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              failed;
    } pool_reply_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        opcode_t              op;
        logic                 given;
        logic [SLOT_W-1:0]    slot;
        logic [ALLOWED_W-1:0] blocks;
        int                   reps;
        bit                   typed;
        logic [SLOT_W-1:0]    exp_slot;
        logic                 exp_failed;
    } dir_row_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_WILD} load_mode_t;

    localparam int IDLE_LIMIT = 2000;
    localparam int NUM_ROWS   = 15;
    localparam int NUM_PHASES = 12;
    localparam int RANDOM_CAP = -1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ALLOWED_W-1:0] cfg_wdata;

    fsfl_req_if req_ch();
    fsfl_rsp_if rsp_ch();

    fixed_slot_free_list_allocator i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // mirror of the pool
    logic [LINK_W-1:0] link_mem [SLOT_SPACE];
    logic [LINK_W-1:0] head_slot;
    int                blocks_built;
    int                blocks_cap;
    bit                on_list [SLOT_SPACE];

    pool_reply_t       replies_due [$];
    logic [SLOT_W-1:0] slots_held [$];
    bit                quiet;
    int                idle_cycles;

    int n_items;
    int n_alloc;
    int n_refused;
    int n_grown;
    int n_freed;
    int n_null;
    int n_writes;
    int n_errors;

    dir_row_t dir_rows [NUM_ROWS];

    int         phase_cap   [NUM_PHASES] = '{3, 1, 0, 6, 31, 9, 2, 16, 16,
                                             RANDOM_CAP, RANDOM_CAP, 16};
    load_mode_t phase_mode  [NUM_PHASES] = '{MODE_FILL, MODE_DRAIN, MODE_MIXED,
                                             MODE_FILL, MODE_DRAIN, MODE_FILL,
                                             MODE_MIXED, MODE_FILL, MODE_FILL,
                                             MODE_DRAIN, MODE_MIXED, MODE_WILD};
    int         phase_len   [NUM_PHASES] = '{120, 100, 100, 150, 120, 150, 120,
                                             370, 200, 150, 100, 40};
    bit         phase_quiet [NUM_PHASES] = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0};

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic void link_fresh_block(int b);
        int base;
        int idx;
        base = b * BLOCK_SIZE;
        for (int i = 0; i < BLOCK_SIZE; i++)
        begin
            idx = (base + i) % SLOT_SPACE;
            if (i == BLOCK_SIZE - 1)
                link_mem[idx] = head_slot;
            else
                link_mem[idx] = LINK_W'(base + i + 1);
            on_list[idx] = 1'b1;
        end
        head_slot = LINK_W'(base);
    endfunction

    function automatic pool_reply_t next_reply(opcode_t op, logic given,
                                               logic [SLOT_W-1:0] slot);
        pool_reply_t       r;
        logic [SLOT_W-1:0] got;
        r = '0;
        if (op == OP_FREE)
        begin
            if (given)
            begin
                link_mem[slot] = head_slot;
                head_slot      = {1'b0, slot};
                on_list[slot]  = 1'b1;
                r.slot         = slot;
                n_freed++;
            end
            else
                n_null++;
            return r;
        end
        if (head_slot == NULL_LINK)
        begin
            if (blocks_built >= blocks_cap || blocks_built >= MAX_BLOCKS ||
                (blocks_built + 1) * BLOCK_SIZE > SLOT_SPACE)
            begin
                r.failed = 1'b1;
                n_refused++;
                return r;
            end
            link_fresh_block(blocks_built);
            blocks_built++;
            n_grown++;
        end
        got          = head_slot[SLOT_W-1:0];
        head_slot    = link_mem[got];
        on_list[got] = 1'b0;
        r.slot       = got;
        n_alloc++;
        return r;
    endfunction

    function automatic int sender_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue_request(opcode_t op, logic given, logic [SLOT_W-1:0] slot,
                                 bit typed, pool_reply_t typed_reply);
        pool_reply_t r;
        int          gap;
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.slot_given <= given;
        req_ch.slot_index <= slot;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = next_reply(op, given, slot);
        replies_due.push_back(typed ? typed_reply : r);
        if (op == OP_ALLOC && !r.failed)
            slots_held.push_back(r.slot);
        n_items++;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_blocks_allowed(logic [ALLOWED_W-1:0] v);
        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        blocks_cap = int'(v);
        n_writes++;
    endtask

    // response side
    initial
    begin
        int hold;
        int stall;
        int r;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            hold = $urandom_range(1, 8);
            repeat (hold) @(posedge clk);
            r = $urandom_range(0, 99);
            stall = (quiet || r < 40) ? 0 :
                    (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        pool_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, got slot %0d failed %0b",
                         $time, rsp_ch.slot_index_out, rsp_ch.alloc_failed);
                n_errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp_ch.slot_index_out !== want.slot)
                begin
                    $display("%0t: slot_index_out mismatch, expected %0d, got %0d",
                             $time, want.slot, rsp_ch.slot_index_out);
                    n_errors++;
                end
                if (rsp_ch.alloc_failed !== want.failed)
                begin
                    $display("%0t: alloc_failed mismatch, expected %0b, got %0b",
                             $time, want.failed, rsp_ch.alloc_failed);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        opcode_t           op;
        logic              given;
        logic [SLOT_W-1:0] slot;
        load_mode_t        mode;
        int                alloc_pct;
        int                pct;
        int                pick;
        int                idx;
        int                cap;
        bit                found;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_ALLOC;
        req_ch.slot_given = 1'b0;
        req_ch.slot_index = '0;
        quiet             = 1'b0;
        idle_cycles       = 0;
        n_items = 0; n_alloc = 0; n_refused = 0; n_grown = 0;
        n_freed = 0; n_null = 0; n_writes = 0; n_errors = 0;

        foreach (link_mem[i])
        begin
            link_mem[i] = '0;
            on_list[i]  = 1'b0;
        end
        head_slot = NULL_LINK;
        link_fresh_block(0);
        blocks_built = 1;
        blocks_cap   = int'(ALLOWED_RESET);

        dir_rows = '{
            '{ROW_ITEM, OP_ALLOC, 1'b0, 8'd0,   5'd0,  1,  1'b1, 8'd0,   1'b0},
            '{ROW_ITEM, OP_FREE,  1'b0, 8'd255, 5'd0,  1,  1'b1, 8'd0,   1'b0},
            '{ROW_ITEM, OP_FREE,  1'b1, 8'd255, 5'd0,  1,  1'b1, 8'd255, 1'b0},
            '{ROW_ITEM, OP_ALLOC, 1'b0, 8'd0,   5'd0,  1,  1'b1, 8'd255, 1'b0},
            '{ROW_CFG,  OP_ALLOC, 1'b0, 8'd0,   5'd1,  0,  1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, OP_ALLOC, 1'b1, 8'd255, 5'd0,  15, 1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, OP_ALLOC, 1'b0, 8'd0,   5'd0,  1,  1'b1, 8'd0,   1'b1},
            '{ROW_ITEM, OP_FREE,  1'b0, 8'd0,   5'd0,  1,  1'b1, 8'd0,   1'b0},
            '{ROW_CFG,  OP_ALLOC, 1'b0, 8'd0,   5'd2,  0,  1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, OP_ALLOC, 1'b0, 8'd0,   5'd0,  1,  1'b1, 8'd16,  1'b0},
            '{ROW_ITEM, OP_FREE,  1'b1, 8'd170, 5'd0,  1,  1'b1, 8'd170, 1'b0},
            '{ROW_ITEM, OP_FREE,  1'b1, 8'd85,  5'd0,  1,  1'b1, 8'd85,  1'b0},
            '{ROW_ITEM, OP_ALLOC, 1'b0, 8'd0,   5'd0,  1,  1'b1, 8'd85,  1'b0},
            '{ROW_ITEM, OP_ALLOC, 1'b0, 8'd0,   5'd0,  1,  1'b1, 8'd170, 1'b0},
            '{ROW_CFG,  OP_ALLOC, 1'b0, 8'd0,   5'd16, 0,  1'b0, 8'd0,   1'b0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
                set_blocks_allowed(dir_rows[r].blocks);
            else
                repeat (dir_rows[r].reps)
                    issue_request(dir_rows[r].op, dir_rows[r].given, dir_rows[r].slot,
                                  dir_rows[r].typed,
                                  '{slot: dir_rows[r].exp_slot,
                                    failed: dir_rows[r].exp_failed});
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            cap = (phase_cap[p] == RANDOM_CAP) ? $urandom_range(1, 16) : phase_cap[p];
            set_blocks_allowed(ALLOWED_W'(cap));
            quiet = phase_quiet[p];
            mode  = phase_mode[p];
            alloc_pct = (mode == MODE_FILL)  ? 85 :
                        (mode == MODE_DRAIN) ? 20 :
                        (mode == MODE_MIXED) ? 50 : 45;
            for (int k = 0; k < phase_len[p]; k++)
            begin
                op    = OP_ALLOC;
                given = 1'($urandom);
                slot  = SLOT_W'($urandom);
                pct   = $urandom_range(0, 99);
                if (pct >= alloc_pct)
                begin
                    op    = OP_FREE;
                    given = 1'b1;
                    pick  = $urandom_range(0, 99);
                    found = 1'b0;
                    if (pick < 10)
                        given = 1'b0;
                    else if (mode == MODE_WILD)
                    begin
                        // free a slot already on the list: the list turns cyclic
                        if (pick < 50 && head_slot != NULL_LINK)
                            slot = head_slot[SLOT_W-1:0];
                    end
                    else if (pick < 16)
                    begin
                        for (int t = 0; t < 8 && !found; t++)
                        begin
                            slot  = SLOT_W'($urandom);
                            found = !on_list[slot];
                        end
                        if (!found)
                            given = 1'b0;
                    end
                    else
                    begin
                        while (!found && slots_held.size() > 0)
                        begin
                            idx  = $urandom_range(0, slots_held.size() - 1);
                            slot = slots_held[idx];
                            slots_held.delete(idx);
                            found = !on_list[slot];
                        end
                        if (!found)
                            op = OP_ALLOC;
                    end
                end
                issue_request(op, given, slot, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        quiet = 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("ran %0d requests over %0d register writes: %0d allocations, %0d refused",
                 n_items, n_writes, n_alloc, n_refused);
        $display("pool grew %0d times to %0d blocks; %0d frees and %0d null frees",
                 n_grown, blocks_built, n_freed, n_null);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/fsfl_pkg.sv
rtl/fsfl_if.sv
rtl/fixed_slot_free_list_allocator.sv
bench/tb.sv
